### hw/rtl/swsd_pkg.sv
`timescale 1ns / 1ps

package swsd_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_POP       = 3'd1;
    localparam logic [2:0] CMD_PEEK      = 3'd2;
    localparam logic [2:0] CMD_DUMP_ASC  = 3'd3;
    localparam logic [2:0] CMD_DUMP_DESC = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

endpackage

### hw/rtl/swsd_ram.sv
`timescale 1ns / 1ps

module swsd_ram #(
    parameter int DEPTH_P  = 16,
    parameter int DATA_W_P = 32,
    parameter int ADDR_W_P = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic                rd_en,
    input  logic [ADDR_W_P-1:0] addr,
    input  logic [DATA_W_P-1:0] wdata,
    output logic [DATA_W_P-1:0] rdata
);

    logic [DATA_W_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### hw/rtl/swsd_ctrl.sv
`timescale 1ns / 1ps

module swsd_ctrl
    import swsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               cmd,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] result_value,
    output logic [1:0]               status,
    output logic                     last,
    output mem_req_t                 stk_req,
    input  logic [DATA_W-1:0]        stk_rdata,
    output mem_req_t                 scr_req,
    input  logic [DATA_W-1:0]        scr_rdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_EMIT,
        S_SORT_POP,
        S_SORT_T,
        S_CMP_RD,
        S_CMP,
        S_PUT,
        S_DRAIN,
        S_DRAIN_WR,
        S_DUMP_RD,
        S_DUMP_WAIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         aux_reg, aux_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic                     desc_reg, desc_next;
    logic [DATA_W-1:0]        t_reg, t_next;
    logic [DATA_W-1:0]        pend_value_reg, pend_value_next;
    logic [1:0]               pend_status_reg, pend_status_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        out_value_reg, out_value_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic                     out_last_reg, out_last_next;

    logic [CNT_W-1:0]  cnt_dec;
    logic [CNT_W-1:0]  aux_dec;
    logic [ADDR_W-1:0] cnt_addr;
    logic [ADDR_W-1:0] cnt_dec_addr;
    logic [ADDR_W-1:0] aux_addr;
    logic [ADDR_W-1:0] aux_dec_addr;
    logic              out_free;
    logic              dump_final;

    assign cnt_dec      = cnt_reg - CNT_W'(1);
    assign aux_dec      = aux_reg - CNT_W'(1);
    assign cnt_addr     = cnt_reg[ADDR_W-1:0];
    assign cnt_dec_addr = cnt_dec[ADDR_W-1:0];
    assign aux_addr     = aux_reg[ADDR_W-1:0];
    assign aux_dec_addr = aux_dec[ADDR_W-1:0];
    assign out_free     = !out_valid_reg || out_ready;
    assign dump_final   = ({1'b0, idx_reg} == cnt_dec);

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        aux_next         = aux_reg;
        idx_next         = idx_reg;
        desc_next        = desc_reg;
        t_next           = t_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        stk_req          = '0;
        scr_req          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_PUSH:
                        begin
                            state_next = S_EMIT;
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                pend_value_next  = '0;
                                pend_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                stk_req.wr_en    = 1'b1;
                                stk_req.addr     = cnt_addr;
                                stk_req.wdata    = value;
                                cnt_next         = cnt_reg + CNT_W'(1);
                                pend_value_next  = value;
                                pend_status_next = ST_OK;
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_value_next  = (cmd == CMD_POP) ? POP_EMPTY_VALUE : '0;
                                pend_status_next = ST_UNDERFLOW;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                stk_req.rd_en = 1'b1;
                                stk_req.addr  = cnt_dec_addr;
                                if (cmd == CMD_POP)
                                begin
                                    cnt_next = cnt_dec;
                                end
                                state_next = S_RD_WAIT;
                            end
                        end
                        CMD_DUMP_ASC, CMD_DUMP_DESC:
                        begin
                            desc_next = (cmd == CMD_DUMP_DESC);
                            if (cnt_reg == '0)
                            begin
                                pend_value_next  = '0;
                                pend_status_next = ST_EMPTY;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                aux_next   = '0;
                                state_next = S_SORT_POP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                pend_value_next  = stk_rdata;
                pend_status_next = ST_OK;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_status_next = pend_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SORT_POP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    stk_req.rd_en = 1'b1;
                    stk_req.addr  = cnt_dec_addr;
                    cnt_next      = cnt_dec;
                    state_next    = S_SORT_T;
                end
            end
            S_SORT_T:
            begin
                t_next     = stk_rdata;
                state_next = S_CMP_RD;
            end
            S_CMP_RD:
            begin
                if (aux_reg == '0)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    scr_req.rd_en = 1'b1;
                    scr_req.addr  = aux_dec_addr;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                if ($signed(scr_rdata) < $signed(t_reg))
                begin
                    aux_next      = aux_dec;
                    stk_req.wr_en = 1'b1;
                    stk_req.addr  = cnt_addr;
                    stk_req.wdata = scr_rdata;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    state_next    = S_CMP_RD;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                scr_req.wr_en = 1'b1;
                scr_req.addr  = aux_addr;
                scr_req.wdata = t_reg;
                aux_next      = aux_reg + CNT_W'(1);
                state_next    = S_SORT_POP;
            end
            S_DRAIN:
            begin
                if (aux_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = S_DUMP_RD;
                end
                else
                begin
                    scr_req.rd_en = 1'b1;
                    scr_req.addr  = aux_dec_addr;
                    aux_next      = aux_dec;
                    state_next    = S_DRAIN_WR;
                end
            end
            S_DRAIN_WR:
            begin
                stk_req.wr_en = 1'b1;
                stk_req.addr  = cnt_addr;
                stk_req.wdata = scr_rdata;
                cnt_next      = cnt_reg + CNT_W'(1);
                state_next    = S_DRAIN;
            end
            S_DUMP_RD:
            begin
                stk_req.rd_en = 1'b1;
                stk_req.addr  = desc_reg ? (cnt_dec_addr - idx_reg) : idx_reg;
                state_next    = S_DUMP_WAIT;
            end
            S_DUMP_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = stk_rdata;
                    out_status_next = ST_OK;
                    out_last_next   = dump_final;
                    if (dump_final)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            aux_reg       <= '0;
            idx_reg       <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            aux_reg       <= aux_next;
            idx_reg       <= idx_next;
            desc_reg      <= desc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg           <= t_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

endmodule

### hw/rtl/stack_with_sort_dump.sv
`timescale 1ns / 1ps
// Push, underflow, overflow and empty dump: the result passes through S_EMIT to the output register;
// pop and peek first read the stack in S_RD_WAIT. S_EMIT holds while the output is stalled.
// A new transaction is taken only once the result is loaded into the output register.
// Sort and dump of n words: an insertion pass through the single-port stack and scratch
// memories, a drain back to the stack, then each word read in S_DUMP_RD and sent in S_DUMP_WAIT.
// Reset clears the count and the control state; the memories are not cleared.

module stack_with_sort_dump
    import swsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               cmd,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] result_value,
    output logic [1:0]               status,
    output logic                     last
);

    mem_req_t          stk_req;
    mem_req_t          scr_req;
    logic [DATA_W-1:0] stk_rdata;
    logic [DATA_W-1:0] scr_rdata;

    swsd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .last         (last),
        .stk_req      (stk_req),
        .stk_rdata    (stk_rdata),
        .scr_req      (scr_req),
        .scr_rdata    (scr_rdata)
    );

    swsd_ram #(
        .DEPTH_P  (DEPTH),
        .DATA_W_P (DATA_W),
        .ADDR_W_P (ADDR_W)
    ) u_stack_ram (
        .clk   (clk),
        .wr_en (stk_req.wr_en),
        .rd_en (stk_req.rd_en),
        .addr  (stk_req.addr),
        .wdata (stk_req.wdata),
        .rdata (stk_rdata)
    );

    swsd_ram #(
        .DEPTH_P  (DEPTH),
        .DATA_W_P (DATA_W),
        .ADDR_W_P (ADDR_W)
    ) u_scratch_ram (
        .clk   (clk),
        .wr_en (scr_req.wr_en),
        .rd_en (scr_req.rd_en),
        .addr  (scr_req.addr),
        .wdata (scr_req.wdata),
        .rdata (scr_rdata)
    );

endmodule
